### hdl/fgrc_pkg.sv
package fgrc_pkg;

   localparam int WORD_W       = 16;
   localparam int ACC_W        = 32;
   localparam int VALUE_W      = 27;
   localparam int REM_W        = 26;
   localparam int QUOT_W       = 7;
   localparam int DIV_STEPS    = QUOT_W;
   localparam int DIVISOR_W    = 20;
   localparam int SCALE_MILLI  = 1000;
   localparam int PERCENT_FULL = 100;
   // percent = rem * 100 / (design * 1000) = rem / (design * 10)
   localparam int DIV_SCALE    = SCALE_MILLI / PERCENT_FULL;

   localparam logic STATUS_OK          = 1'b0;
   localparam logic STATUS_UNSUPPORTED = 1'b1;

   typedef enum logic [2:0] {
      MODE_VOLTAGE = 3'd0,
      MODE_CURRENT = 3'd1,
      MODE_DESIGN  = 3'd2,
      MODE_REMAIN  = 3'd3,
      MODE_PERCENT = 3'd4
   } mode_type;

   typedef struct packed {
      logic                      is_div;
      logic                      status;
      logic signed [VALUE_W-1:0] value;
      logic        [REM_W-1:0]   rem;
      logic        [REM_W-1:0]   divisor;
      logic        [QUOT_W-1:0]  quot;
   } div_beat_type;

endpackage

### hdl/fuel_gauge_reading_converter.sv
// Path from an accepted request beat to its response beat: two prep stages,
// then seven divide cells, one quotient bit per cell.
// Throughput: one beat per cycle; the whole row advances together and
// stalls only while a finished response waits on rsp_ready.
// Reset: synchronous, active high; clears all valid bits, payload is not reset.
module fuel_gauge_reading_converter
   import fgrc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [2:0]                req_mode,
   input  logic [WORD_W-1:0]         req_reg_word,
   input  logic signed [ACC_W-1:0]   req_accumulated_uah,
   input  logic [WORD_W-1:0]         req_design_mah,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [VALUE_W-1:0] rsp_value,
   output logic                      rsp_status
);

   logic         advance;
   logic         cell_valid [0:DIV_STEPS];
   div_beat_type cell_beat  [0:DIV_STEPS];
   div_beat_type last_beat;

   // Advance the row whenever the last cell is empty or being drained.
   assign advance   = !cell_valid[DIV_STEPS] || rsp_ready;
   assign req_ready = advance;

   // Scale, clamp and line up the divisor for the percent divide.
   fgrc_prep u_prep (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .in_valid    (req_valid),
      .in_mode     (req_mode),
      .in_reg_word (req_reg_word),
      .in_acc      (req_accumulated_uah),
      .in_design   (req_design_mah),
      .out_valid   (cell_valid[0]),
      .out_beat    (cell_beat[0])
   );

   // Row of restoring divide cells; beats that need no divide ride along.
   for (genvar g = 0; g < DIV_STEPS; g++) begin : g_cell
      fgrc_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (cell_valid[g]),
         .in_beat   (cell_beat[g]),
         .out_valid (cell_valid[g+1]),
         .out_beat  (cell_beat[g+1])
      );
   end

   assign last_beat  = cell_beat[DIV_STEPS];
   assign rsp_valid  = cell_valid[DIV_STEPS];
   assign rsp_status = last_beat.status;

   // Select the quotient for a beat that was divided, the carried value otherwise.
   always_comb begin
      if (last_beat.is_div) begin
         rsp_value = VALUE_W'(last_beat.quot);
      end else begin
         rsp_value = last_beat.value;
      end
   end

   a_unsupported_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_UNSUPPORTED) |-> (rsp_value == '0))
      else $error("unsupported mode with nonzero value");

   a_percent_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && last_beat.is_div |-> (last_beat.quot <= QUOT_W'(PERCENT_FULL)))
      else $error("percent above full");

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while the row is stalled");

endmodule

### hdl/fgrc_prep.sv
module fgrc_prep
   import fgrc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic                     in_valid,
   input  logic [2:0]               in_mode,
   input  logic [WORD_W-1:0]        in_reg_word,
   input  logic signed [ACC_W-1:0]  in_acc,
   input  logic [WORD_W-1:0]        in_design,
   output logic                     out_valid,
   output div_beat_type             out_beat
);

   // stage 1: scale by the milli factor
   logic signed [WORD_W:0]    word_op;
   logic signed [VALUE_W:0]   word_prod;
   logic [REM_W-1:0]          full_in;

   logic                      s1_valid_ff;
   mode_type                  s1_mode_ff;
   logic signed [VALUE_W-1:0] s1_scaled_ff;
   logic [WORD_W-1:0]         s1_word_ff;
   logic [WORD_W-1:0]         s1_design_ff;
   logic [REM_W-1:0]          s1_full_ff;
   logic signed [ACC_W-1:0]   s1_acc_ff;

   // stage 2: clamp and form the divide beat
   logic signed [REM_W+7:0]   sum;
   logic [REM_W-1:0]          clamped;
   logic [DIVISOR_W-1:0]      div_base;
   div_beat_type              beat_in;
   logic                      s2_valid_ff;
   div_beat_type              s2_beat_ff;

   always_comb begin
      if (mode_type'(in_mode) == MODE_CURRENT) begin
         word_op = $signed({in_reg_word[WORD_W-1], in_reg_word});
      end else begin
         word_op = $signed({1'b0, in_reg_word});
      end
      word_prod = word_op * $signed(12'(SCALE_MILLI));
      full_in   = REM_W'(in_design) * REM_W'(SCALE_MILLI);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_mode_ff   <= mode_type'(in_mode);
         s1_scaled_ff <= word_prod[VALUE_W-1:0];
         s1_word_ff   <= in_reg_word;
         s1_design_ff <= in_design;
         s1_full_ff   <= full_in;
         s1_acc_ff    <= in_acc;
      end
   end

   always_comb begin
      sum = $signed({8'd0, s1_full_ff}) + $signed({{2{s1_acc_ff[ACC_W-1]}}, s1_acc_ff});
      if (sum[REM_W+7]) begin
         clamped = '0;
      end else if (sum > $signed({8'd0, s1_full_ff})) begin
         clamped = s1_full_ff;
      end else begin
         clamped = sum[REM_W-1:0];
      end
      div_base = DIVISOR_W'(s1_design_ff) * DIVISOR_W'(DIV_SCALE);

      beat_in.is_div  = 1'b0;
      beat_in.status  = STATUS_OK;
      beat_in.value   = '0;
      beat_in.rem     = clamped;
      beat_in.divisor = REM_W'(div_base) << (QUOT_W - 1);
      beat_in.quot    = '0;
      case (s1_mode_ff)
         MODE_VOLTAGE, MODE_CURRENT: begin
            beat_in.value = s1_scaled_ff;
         end
         MODE_DESIGN: begin
            beat_in.value = VALUE_W'(s1_word_ff);
         end
         MODE_REMAIN: begin
            beat_in.value = VALUE_W'(clamped);
         end
         MODE_PERCENT: begin
            // zero design leaves value at zero and skips the divide
            beat_in.is_div = (s1_design_ff != '0);
         end
         default: begin
            beat_in.status = STATUS_UNSUPPORTED;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_beat_ff <= beat_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_beat  = s2_beat_ff;

endmodule

### hdl/fgrc_div_cell.sv
module fgrc_div_cell
   import fgrc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         advance,
   input  logic         in_valid,
   input  div_beat_type in_beat,
   output logic         out_valid,
   output div_beat_type out_beat
);

   logic         take;
   div_beat_type beat_in;
   logic         valid_ff;
   div_beat_type beat_ff;

   // one restoring step: subtract the aligned divisor if it fits, shift it down
   always_comb begin
      take            = (in_beat.rem >= in_beat.divisor);
      beat_in         = in_beat;
      beat_in.quot    = {in_beat.quot[QUOT_W-2:0], take};
      beat_in.divisor = in_beat.divisor >> 1;
      if (take) begin
         beat_in.rem = in_beat.rem - in_beat.divisor;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         beat_ff <= beat_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_beat  = beat_ff;

   a_rem_bounded: assert property (@(posedge clock) disable iff (reset)
      out_valid && out_beat.is_div |->
         ({1'b0, out_beat.rem} < {out_beat.divisor, 1'b0}))
      else $error("partial remainder exceeds twice the divisor");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(out_valid) && (!out_valid || $stable(out_beat)))
      else $error("cell changed while stalled");

   a_valid_moves: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid == $past(in_valid))
      else $error("valid did not follow its neighbor");

endmodule
